// File: src/baa_pkg.sv
// types, widths and codes shared by the bump arena allocator
package baa_pkg;

  localparam int unsigned FIELD_W = 21;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OFS_W   = FIELD_W + 1;

  localparam logic [FIELD_W-1:0] DEFAULT_ALIGN = FIELD_W'(8);
  localparam logic [OFS_W-1:0]   CAP_GRAIN_M1  = OFS_W'(15);

  typedef enum logic [0:0] {
    CFG_CAPACITY = 1'b0,
    CFG_BUDGET   = 1'b1
  } baa_cfg_idx_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_RESET = 1'b1
  } baa_op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNINIT = 3'd1,
    ST_ZERO   = 3'd2,
    ST_FULL   = 3'd3,
    ST_BUDGET = 3'd4,
    ST_RESET  = 3'd5
  } baa_status_t;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] alignment;
  } baa_req_t;

  typedef struct packed {
    logic               granted;
    baa_status_t        status;
    logic [FIELD_W-1:0] block_offset;
    logic [FIELD_W-1:0] used_bytes;
    logic [FIELD_W-1:0] peak_bytes;
    logic [CNT_W-1:0]   resets_seen;
    logic [CNT_W-1:0]   failures_seen;
    logic [CNT_W-1:0]   budget_overruns;
  } baa_rsp_t;

endpackage

// File: src/baa_chan_if.sv
// valid/ready channel interface carrying one payload per transaction
interface baa_chan_if
  import baa_pkg::*;
#(
  parameter type payload_t = baa_req_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/baa_in_stage.sv
// input register holding one request transaction
module baa_in_stage
  import baa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  baa_chan_if.sink in_chan,
  input  logic     space,
  output logic     commit,
  output baa_req_t req
);

  logic     valid_r;
  logic     valid_nxt;
  baa_req_t req_r;

  assign in_chan.ready = !valid_r || space;
  assign commit        = valid_r && space;
  assign req           = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      req_r <= in_chan.payload;
    end
  end

endmodule

// File: src/baa_core.sv
// arena state, configuration registers and allocation decision
module baa_core
  import baa_pkg::*;
#(
  parameter int unsigned ARENA_MAX_BYTES = 1048576
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  baa_cfg_idx_t       cfg_index,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               commit,
  input  baa_req_t           req,
  output baa_rsp_t           rsp
);

  localparam logic [31:0] MAX_L = 32'(ARENA_MAX_BYTES);

  logic [FIELD_W-1:0] cap_r;
  logic [FIELD_W-1:0] budget_r;
  logic [OFS_W-1:0]   offset_r, offset_nxt;
  logic [OFS_W-1:0]   peak_r, peak_nxt;
  logic [CNT_W-1:0]   resets_r, resets_nxt;
  logic [CNT_W-1:0]   fails_r, fails_nxt;
  logic [CNT_W-1:0]   overruns_r, overruns_nxt;

  logic [FIELD_W-1:0] align_eff;
  logic [FIELD_W-1:0] align_m1;
  logic [OFS_W:0]     aligned;
  logic [OFS_W+1:0]   end_ofs;
  logic [OFS_W-1:0]   cap_round;
  logic [OFS_W-1:0]   cap_eff;
  logic               full;
  logic               over_budget;
  logic               granted;
  baa_status_t        status;

  always_comb begin
    align_eff   = (req.alignment == '0) ? DEFAULT_ALIGN : req.alignment;
    align_m1    = align_eff - FIELD_W'(1);
    aligned     = ({1'b0, offset_r} + {2'b00, align_m1}) & ~{2'b00, align_m1};
    end_ofs     = {1'b0, aligned} + {3'b000, req.request_size};
    cap_round   = ({1'b0, cap_r} + CAP_GRAIN_M1) & ~CAP_GRAIN_M1;
    cap_eff     = ({10'b0, cap_round} > MAX_L) ? MAX_L[OFS_W-1:0] : cap_round;
    full        = end_ofs > {2'b00, cap_eff};
    over_budget = (budget_r != '0) && (end_ofs > {3'b000, budget_r});
  end

  always_comb begin
    offset_nxt   = offset_r;
    peak_nxt     = peak_r;
    resets_nxt   = resets_r;
    fails_nxt    = fails_r;
    overruns_nxt = overruns_r;
    granted      = 1'b0;
    priority if (cap_r == '0) begin
      status = ST_UNINIT;
    end else if (req.operation == OP_RESET) begin
      status     = ST_RESET;
      offset_nxt = '0;
      resets_nxt = resets_r + CNT_W'(1);
    end else if (req.request_size == '0) begin
      status = ST_ZERO;
    end else if (full) begin
      status    = ST_FULL;
      fails_nxt = fails_r + CNT_W'(1);
    end else if (over_budget) begin
      status       = ST_BUDGET;
      fails_nxt    = fails_r + CNT_W'(1);
      overruns_nxt = overruns_r + CNT_W'(1);
    end else begin
      status     = ST_OK;
      granted    = 1'b1;
      offset_nxt = end_ofs[OFS_W-1:0];
      if (end_ofs[OFS_W-1:0] > peak_r) begin
        peak_nxt = end_ofs[OFS_W-1:0];
      end
    end
  end

  always_comb begin
    rsp.granted         = granted;
    rsp.status          = status;
    rsp.block_offset    = granted ? aligned[FIELD_W-1:0] : '0;
    rsp.used_bytes      = offset_nxt[FIELD_W-1:0];
    rsp.peak_bytes      = peak_nxt[FIELD_W-1:0];
    rsp.resets_seen     = resets_nxt;
    rsp.failures_seen   = fails_nxt;
    rsp.budget_overruns = overruns_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      budget_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r    <= cfg_wdata;
        CFG_BUDGET:   budget_r <= cfg_wdata;
        default:      cap_r    <= cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      peak_r     <= '0;
      resets_r   <= '0;
      fails_r    <= '0;
      overruns_r <= '0;
    end else if (commit) begin
      offset_r   <= offset_nxt;
      peak_r     <= peak_nxt;
      resets_r   <= resets_nxt;
      fails_r    <= fails_nxt;
      overruns_r <= overruns_nxt;
    end
  end

  a_offset_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= peak_r)
    else $error("arena offset above peak");

  a_budget_counts_both: assert property (@(posedge clk) disable iff (!rst_n)
    commit && status == ST_BUDGET |=>
      overruns_r == $past(overruns_r) + CNT_W'(1) &&
      fails_r == $past(fails_r) + CNT_W'(1))
    else $error("budget refusal not counted in both counters");

  a_refusal_keeps_offset: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !granted && status != ST_RESET |=> $stable(offset_r) && $stable(peak_r))
    else $error("refused transaction moved the offset");

  a_grant_fits_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    commit && granted |=> offset_r <= $past(cap_eff))
    else $error("granted block extends past capacity");

endmodule

// File: src/baa_out_stage.sv
// result register toward the receiver
module baa_out_stage
  import baa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       commit,
  input  baa_rsp_t   rsp,
  output logic       space,
  baa_chan_if.source out_chan
);

  logic     valid_r;
  logic     valid_nxt;
  baa_rsp_t rsp_r;

  assign space            = !valid_r || out_chan.ready;
  assign out_chan.valid   = valid_r;
  assign out_chan.payload = rsp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (space) begin
      valid_nxt = commit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_r <= rsp;
    end
  end

endmodule

// File: src/bump_arena_allocator.sv
// top level of the bump-pointer frame arena allocator
// usage:
//   in_chan carries one request per transaction: operation (allocate or
//   frame reset), request_size and alignment (zero selects 8 bytes).
//   out_chan returns exactly one result per request, in order: grant flag,
//   status, block offset, used and peak bytes and the three counters.
//   cfg_wr_en/cfg_index/cfg_wdata write capacity (index 0) or budget
//   (index 1); write only while no transaction is in flight.
// timing:
//   a request is registered on acceptance, decided against the arena
//   offset once the result register has space and then held in the
//   result register until out_chan takes it.
//   one transaction per cycle sustained while out_chan is ready; the single
//   offset register with its align/add/compare path sets that figure.
// reset:
//   rst_n clears capacity, budget, offset, peak and counters; the arena
//   is uninitialized until capacity is written nonzero.
// stall:
//   when out_chan is not ready the result holds, one more request waits in
//   the input register and in_chan.ready then drops.
module bump_arena_allocator
  import baa_pkg::*;
#(
  parameter int unsigned ARENA_MAX_BYTES = 1048576
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  baa_cfg_idx_t       cfg_index,
  input  logic [FIELD_W-1:0] cfg_wdata,
  baa_chan_if.sink           in_chan,
  baa_chan_if.source         out_chan
);

  logic     space;
  logic     commit;
  baa_req_t req;
  baa_rsp_t rsp;

  baa_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .space   (space),
    .commit  (commit),
    .req     (req)
  );

  baa_core #(
    .ARENA_MAX_BYTES (ARENA_MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .commit    (commit),
    .req       (req),
    .rsp       (rsp)
  );

  baa_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .commit   (commit),
    .rsp      (rsp),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule

// File: tb/sv/tb_bump_arena_allocator.sv
// testbench for the bump arena allocator: directed and random requests checked against a predictor
module tb_bump_arena_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import baa_pkg::*;

  localparam int unsigned ARENA_LIMIT = 1048576;
  localparam logic [FIELD_W-1:0] FIELD_ONES = '1;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  baa_cfg_idx_t cfg_index;
  logic [FIELD_W-1:0] cfg_wdata;

  baa_chan_if #(.payload_t(baa_req_t)) req_chan ();
  baa_chan_if #(.payload_t(baa_rsp_t)) rsp_chan ();

  bump_arena_allocator #(.ARENA_MAX_BYTES(ARENA_LIMIT)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  // predictor state and its copy of the registers
  logic [FIELD_W-1:0] arena_capacity;
  logic [FIELD_W-1:0] arena_budget;
  logic [FIELD_W-1:0] arena_offset;
  logic [FIELD_W-1:0] arena_peak;
  logic [CNT_W-1:0]   arena_resets;
  logic [CNT_W-1:0]   arena_failures;
  logic [CNT_W-1:0]   arena_overruns;

  baa_req_t requests_to_send[$];
  baa_rsp_t predicted_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_issued;
  int unsigned results_seen;
  int unsigned accepted_count;
  int unsigned mismatch_count;
  int unsigned hold_left;
  int unsigned next_hold_at;
  baa_rsp_t want_rsp;
  baa_rsp_t got_rsp;

  task automatic log_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic baa_rsp_t decide_allocation(input baa_req_t req);
    baa_rsp_t r;
    logic [63:0] cap;
    logic [63:0] algn;
    logic [63:0] aligned;
    logic [63:0] sz;
    r = '0;
    r.status = ST_OK;
    if (arena_capacity == '0) begin
      r.status = ST_UNINIT;
    end else if (req.operation == OP_RESET) begin
      arena_offset = '0;
      arena_resets = arena_resets + 1'b1;
      r.status = ST_RESET;
    end else if (req.request_size == '0) begin
      r.status = ST_ZERO;
    end else begin
      cap = (64'(arena_capacity) + 64'(CAP_GRAIN_M1)) & ~64'(CAP_GRAIN_M1);
      if (cap > 64'(ARENA_LIMIT)) cap = 64'(ARENA_LIMIT);
      algn = (req.alignment == '0) ? 64'(DEFAULT_ALIGN) : 64'(req.alignment);
      aligned = (64'(arena_offset) + algn - 64'd1) & ~(algn - 64'd1);
      sz = 64'(req.request_size);
      if (aligned > cap || sz > cap - aligned) begin
        arena_failures = arena_failures + 1'b1;
        r.status = ST_FULL;
      end else if (arena_budget != '0 && aligned + sz > 64'(arena_budget)) begin
        arena_overruns = arena_overruns + 1'b1;
        arena_failures = arena_failures + 1'b1;
        r.status = ST_BUDGET;
      end else begin
        r.granted = 1'b1;
        r.block_offset = FIELD_W'(aligned);
        arena_offset = FIELD_W'(aligned + sz);
        if (arena_offset > arena_peak) arena_peak = arena_offset;
      end
    end
    r.used_bytes = arena_offset;
    r.peak_bytes = arena_peak;
    r.resets_seen = arena_resets;
    r.failures_seen = arena_failures;
    r.budget_overruns = arena_overruns;
    return r;
  endfunction

  function automatic int unsigned usable_bytes();
    int unsigned cap;
    cap = (int'(arena_capacity) + 15) & ~15;
    return (cap > ARENA_LIMIT) ? ARENA_LIMIT : cap;
  endfunction

  task automatic push_request(input baa_op_t op, input int unsigned size,
                              input int unsigned algn);
    baa_req_t req;
    req.operation = op;
    req.request_size = FIELD_W'(size);
    req.alignment = FIELD_W'(algn);
    requests_to_send.push_back(req);
    requests_issued++;
  endtask

  task automatic push_random_request();
    int unsigned span;
    int unsigned size;
    int unsigned algn;
    int unsigned pick;
    span = usable_bytes() / 8;
    if (span == 0) span = 1;
    size = $urandom_range(span, 1);
    pick = $urandom_range(99);
    if (pick < 30) algn = 0;
    else if (pick < 80) algn = 1 << $urandom_range(6, 0);
    else if (pick < 90) algn = 1 << $urandom_range(20, 7);
    else algn = $urandom_range(100, 3);
    pick = $urandom_range(99);
    if (pick < 8) push_request(OP_RESET, $urandom() & FIELD_ONES, $urandom() & FIELD_ONES);
    else if (pick < 12) push_request(OP_ALLOC, 0, algn);
    else if (pick < 17) push_request(OP_ALLOC, $urandom() & FIELD_ONES, $urandom() & FIELD_ONES);
    else push_request(OP_ALLOC, size, algn);
  endtask

  task automatic wait_idle();
    while (results_seen != requests_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input baa_cfg_idx_t idx, input logic [FIELD_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CAPACITY: arena_capacity = val;
      CFG_BUDGET:   arena_budget = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure_arena(input int unsigned cap, input int unsigned budget);
    wait_idle();
    write_reg(CFG_CAPACITY, FIELD_W'(cap));
    write_reg(CFG_BUDGET, FIELD_W'(budget));
  endtask

  task automatic run_random_segment(input int unsigned n);
    int unsigned cap;
    int unsigned budget;
    int unsigned eff;
    case ($urandom_range(9))
      0: cap = 0;
      1: cap = FIELD_ONES;
      2: cap = ARENA_LIMIT;
      3: cap = $urandom_range(16, 1);
      4: cap = $urandom() & FIELD_ONES;
      default: cap = $urandom_range(4096, 16);
    endcase
    eff = (cap + 15) & ~15;
    if (eff > ARENA_LIMIT) eff = ARENA_LIMIT;
    if (eff == 0) eff = 16;
    case ($urandom_range(5))
      0, 1: budget = 0;
      2: budget = $urandom() & FIELD_ONES;
      3: budget = FIELD_ONES;
      default: budget = $urandom_range(eff, 1);
    endcase
    configure_arena(cap, budget);
    repeat (n) push_random_request();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
    end else begin
      if (req_chan.valid && req_chan.ready) begin
        predicted_results.push_back(decide_allocation(req_chan.payload));
        accepted_count++;
      end
      if (!req_chan.valid || req_chan.ready) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_chan.valid <= 1'b1;
          req_chan.payload <= requests_to_send.pop_front();
        end else begin
          req_chan.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      next_hold_at <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_count >= next_hold_at) begin
      hold_left <= 100;
      next_hold_at <= next_hold_at + 450;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) rsp_chan.ready <= 1'b0;
    else rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
      got_rsp = rsp_chan.payload;
      results_seen++;
      if (predicted_results.size() == 0) begin
        log_mismatch($sformatf("unexpected transaction %0d: %p", results_seen, got_rsp));
      end else begin
        want_rsp = predicted_results.pop_front();
        if (got_rsp.granted !== want_rsp.granted)
          log_mismatch($sformatf("#%0d granted %0h, expected %0h", results_seen,
                                 got_rsp.granted, want_rsp.granted));
        if (got_rsp.status !== want_rsp.status)
          log_mismatch($sformatf("#%0d status %0d, expected %0d", results_seen,
                                 got_rsp.status, want_rsp.status));
        if (got_rsp.block_offset !== want_rsp.block_offset)
          log_mismatch($sformatf("#%0d block_offset %0h, expected %0h", results_seen,
                                 got_rsp.block_offset, want_rsp.block_offset));
        if (got_rsp.used_bytes !== want_rsp.used_bytes)
          log_mismatch($sformatf("#%0d used_bytes %0h, expected %0h", results_seen,
                                 got_rsp.used_bytes, want_rsp.used_bytes));
        if (got_rsp.peak_bytes !== want_rsp.peak_bytes)
          log_mismatch($sformatf("#%0d peak_bytes %0h, expected %0h", results_seen,
                                 got_rsp.peak_bytes, want_rsp.peak_bytes));
        if (got_rsp.resets_seen !== want_rsp.resets_seen)
          log_mismatch($sformatf("#%0d resets_seen %0h, expected %0h", results_seen,
                                 got_rsp.resets_seen, want_rsp.resets_seen));
        if (got_rsp.failures_seen !== want_rsp.failures_seen)
          log_mismatch($sformatf("#%0d failures_seen %0h, expected %0h", results_seen,
                                 got_rsp.failures_seen, want_rsp.failures_seen));
        if (got_rsp.budget_overruns !== want_rsp.budget_overruns)
          log_mismatch($sformatf("#%0d budget_overruns %0h, expected %0h", results_seen,
                                 got_rsp.budget_overruns, want_rsp.budget_overruns));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_wdata = '0;
    req_chan.valid = 1'b0;
    req_chan.payload = '0;
    rsp_chan.ready = 1'b0;
    arena_capacity = '0;
    arena_budget = '0;
    arena_offset = '0;
    arena_peak = '0;
    arena_resets = '0;
    arena_failures = '0;
    arena_overruns = '0;
    requests_issued = 0;
    results_seen = 0;
    accepted_count = 0;
    mismatch_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // uninitialized arena
    push_request(OP_ALLOC, 5, 0);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, 0, 0);
    // small arena, alignment corner cases
    configure_arena(100, 0);
    push_request(OP_ALLOC, 0, 0);
    push_request(OP_ALLOC, 1, 0);
    push_request(OP_ALLOC, 1, 16);
    push_request(OP_ALLOC, 2, 3);
    push_request(OP_ALLOC, FIELD_ONES, 1);
    push_request(OP_ALLOC, 1, ARENA_LIMIT);
    push_request(OP_ALLOC, 1, FIELD_ONES);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, 112, 1);
    push_request(OP_ALLOC, 1, 1);
    // budget
    configure_arena(100, 40);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, 41, 1);
    push_request(OP_ALLOC, 40, 0);
    push_request(OP_ALLOC, 1, 0);
    // largest settings
    configure_arena(FIELD_ONES, FIELD_ONES);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, ARENA_LIMIT, 1);
    push_request(OP_ALLOC, 1, 0);
    // shrink below the current offset
    configure_arena(1, 0);
    push_request(OP_ALLOC, 1, 0);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, 16, 0);
    // back to uninitialized
    configure_arena(0, 0);
    push_request(OP_RESET, 0, 0);
    push_request(OP_ALLOC, 4, 0);

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_idle_pct = 37; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) run_random_segment(104);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
